// ----- hw/rtl/rfp_pkg.sv -----
// rfp_pkg: shared types, fixed-point constants and the arctangent table
// for the rectangle frame projection block. No dependencies.
package rfp_pkg;

  // fixed-point formats
  localparam int FRAC_BITS     = 16;
  localparam int CORE_FRAC     = 30;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  typedef logic signed [33:0] ang_q30_t;
  typedef logic signed [31:0] vec_q30_t;
  typedef logic [4:0]         stage_idx_t;

  // angle reduction constants, Q30 radians, and the CORDIC gain in Q30
  localparam ang_q30_t PI_Q30       = 34'sd3373259426;
  localparam ang_q30_t NEG_PI_Q30   = -34'sd3373259426;
  localparam ang_q30_t HALF_PI_Q30  = 34'sd1686629713;
  localparam ang_q30_t NEG_HALF_PI  = -34'sd1686629713;
  localparam ang_q30_t TWO_PI_Q30   = 34'sd6746518852;
  localparam vec_q30_t GAIN_Q30     = 32'sd652032874;

  // field limits
  localparam logic signed [22:0] XY_MAX  = 23'sd131071;
  localparam logic signed [22:0] XY_MIN  = -23'sd131072;
  localparam logic [16:0]        WH_MAX  = 17'd131071;
  localparam logic signed [20:0] ANG_MAX = 21'sd524287;
  localparam logic signed [20:0] ANG_MIN = -21'sd524288;

  // rotator state carried from cell to cell
  typedef struct packed {
    vec_q30_t x;
    vec_q30_t y;
    ang_q30_t z;
    logic     flip;
  } rot_t;

  // per-item data that rides alongside the rotator
  typedef struct packed {
    logic signed [18:0] ox;
    logic signed [18:0] oy;
    logic signed [17:0] fx;
    logic signed [17:0] fy;
    logic [16:0]        rw;
    logic [16:0]        rh;
    logic [16:0]        fw;
    logic [16:0]        fh;
    logic signed [19:0] ang;
  } side_t;

  // atan(2^-i) in Q30
  function automatic vec_q30_t atan_q30(input stage_idx_t i);
    vec_q30_t v;
    case (i)
      5'd0:    v = 32'sd843314857;
      5'd1:    v = 32'sd497837830;
      5'd2:    v = 32'sd263043837;
      5'd3:    v = 32'sd133525159;
      5'd4:    v = 32'sd67021687;
      5'd5:    v = 32'sd33543516;
      5'd6:    v = 32'sd16775851;
      5'd7:    v = 32'sd8388437;
      5'd8:    v = 32'sd4194283;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048576;
      5'd11:   v = 32'sd524288;
      5'd12:   v = 32'sd262144;
      5'd13:   v = 32'sd131072;
      5'd14:   v = 32'sd65536;
      5'd15:   v = 32'sd32768;
      5'd16:   v = 32'sd16384;
      5'd17:   v = 32'sd8192;
      5'd18:   v = 32'sd4096;
      5'd19:   v = 32'sd2048;
      5'd20:   v = 32'sd1024;
      5'd21:   v = 32'sd512;
      5'd22:   v = 32'sd256;
      5'd23:   v = 32'sd128;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/rfp_chan_if.sv -----
// rfp_in_if / rfp_out_if: valid/ready channels of the rectangle frame
// projection block. No dependencies.
interface rfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] rect_x;
  logic signed [17:0] rect_y;
  logic [16:0]        rect_w;
  logic [16:0]        rect_h;
  logic signed [19:0] rect_angle;
  logic signed [17:0] ref_x;
  logic signed [17:0] ref_y;
  logic [16:0]        ref_w;
  logic [16:0]        ref_h;
  logic signed [19:0] ref_angle;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, rect_angle,
                  ref_x, ref_y, ref_w, ref_h, ref_angle, input ready);
  modport sink (input valid, rect_x, rect_y, rect_w, rect_h, rect_angle,
                ref_x, ref_y, ref_w, ref_h, ref_angle, output ready);
endinterface

interface rfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] out_x;
  logic signed [17:0] out_y;
  logic [16:0]        out_w;
  logic [16:0]        out_h;
  logic signed [19:0] out_angle;

  modport source (output valid, out_x, out_y, out_w, out_h, out_angle, input ready);
  modport sink (input valid, out_x, out_y, out_w, out_h, out_angle, output ready);
endinterface

// ----- hw/rtl/rect_frame_projection.sv -----
// rect_frame_projection: top level; input stage, chain of CORDIC cells and
// the scale/translate stages. Depends on rfp_pkg, rfp_chan_if and submodules.
//
// Usage:
//   in_bus carries one rectangle in a reference frame plus the reference
//   rectangle per beat; out_bus returns the projected center, size and
//   angle, one result beat for every input beat, in order.
//   Both channels use valid/ready; a beat moves when both are high.
// Stages: an accepted input beat passes through 1 input stage, 16 CORDIC
//   cells, 3 multiply/round stages and 1 output register before it leaves
//   as its result beat.
// Throughput: one beat per cycle unless out ready stalls it; every cell
//   of the chain and every multiply stage holds a different rectangle.
// Stall: the whole pipeline advances together; while a result waits in the
//   output register with out ready low, in ready is low and every stage
//   holds. Bubbles in the chain do not let extra beats in during a stall.
// Reset: synchronous, active low; clears all valid bits, so nothing is
//   presented on out_bus until new beats arrive. No state across beats.
module rect_frame_projection (
  input  logic      clk,
  input  logic      rst_n,
  rfp_in_if.sink    in_bus,
  rfp_out_if.source out_bus
);
  import rfp_pkg::*;

  logic  en;
  logic  valid_c [NUM_CELLS+1];
  rot_t  rot_c   [NUM_CELLS+1];
  side_t side_c  [NUM_CELLS+1];

  // input stage
  rfp_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_bus  (in_bus),
    .valid_o (valid_c[0]),
    .rot_o   (rot_c[0]),
    .side_o  (side_c[0])
  );

  // cordic cell chain
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    rfp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .idx     (stage_idx_t'(g)),
      .valid_i (valid_c[g]),
      .rot_i   (rot_c[g]),
      .side_i  (side_c[g]),
      .valid_o (valid_c[g+1]),
      .rot_o   (rot_c[g+1]),
      .side_o  (side_c[g+1])
    );
  end

  // rotate, scale, translate and output register
  rfp_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_c[NUM_CELLS]),
    .rot_i   (rot_c[NUM_CELLS]),
    .side_i  (side_c[NUM_CELLS]),
    .en      (en),
    .out_bus (out_bus)
  );

  // a stalled result blocks the input side
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |-> !in_bus.ready)
    else $error("input accepted while output stalled");

  // an accepted beat occupies the input stage next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> valid_c[0])
    else $error("accepted beat lost at input stage");

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid && !valid_c[0])
    else $error("valid bits survive reset");

  // a result leaving frees room at the input
  a_drain_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ready |-> in_bus.ready)
    else $error("input blocked while output drains");
endmodule

// ----- hw/rtl/rfp_cell.sv -----
// rfp_cell: one CORDIC rotation cell of the cell chain, registered output.
// Depends on rfp_pkg.
module rfp_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  rfp_pkg::stage_idx_t idx,
  input  logic               valid_i,
  input  rfp_pkg::rot_t      rot_i,
  input  rfp_pkg::side_t     side_i,
  output logic               valid_o,
  output rfp_pkg::rot_t      rot_o,
  output rfp_pkg::side_t     side_o
);
  import rfp_pkg::*;

  logic     valid_r;
  rot_t     rot_r, rot_nxt;
  side_t    side_r;
  vec_q30_t dx, dy, at;

  // micro-rotation toward zero residual angle
  always_comb begin
    dx      = rot_i.y >>> idx;
    dy      = rot_i.x >>> idx;
    at      = atan_q30(idx);
    rot_nxt = rot_i;
    if (!rot_i.z[$high(rot_i.z)]) begin
      rot_nxt.x = rot_i.x - dx;
      rot_nxt.y = rot_i.y + dy;
      rot_nxt.z = rot_i.z - ang_q30_t'(at);
    end else begin
      rot_nxt.x = rot_i.x + dx;
      rot_nxt.y = rot_i.y - dy;
      rot_nxt.z = rot_i.z + ang_q30_t'(at);
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rot_o   = rot_r;
  assign side_o  = side_r;
endmodule

// ----- hw/rtl/rfp_prep.sv -----
// rfp_prep: input stage; reduces the reference angle, centers the offset
// and sums the angles. Depends on rfp_pkg and rfp_in_if.
module rfp_prep (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  rfp_in_if.sink        in_bus,
  output logic          valid_o,
  output rfp_pkg::rot_t rot_o,
  output rfp_pkg::side_t side_o
);
  import rfp_pkg::*;

  localparam logic signed [18:0] HALF_Q = 19'sd1 <<< (FRAC_BITS - 1);

  logic               valid_r;
  rot_t               rot_r, rot_nxt;
  side_t              side_r, side_nxt;
  ang_q30_t           a0, a1, a2;
  logic               flip;
  logic signed [20:0] asum;

  assign in_bus.ready = en;

  // bring the angle into [-pi/2, pi/2], noting a half-turn
  always_comb begin
    a0 = ang_q30_t'(in_bus.ref_angle) <<< (CORE_FRAC - FRAC_BITS);
    if (a0 > PI_Q30) begin
      a1 = a0 - TWO_PI_Q30;
    end else if (a0 < NEG_PI_Q30) begin
      a1 = a0 + TWO_PI_Q30;
    end else begin
      a1 = a0;
    end
    flip = 1'b0;
    a2   = a1;
    if (a1 > HALF_PI_Q30) begin
      a2   = a1 - PI_Q30;
      flip = 1'b1;
    end else if (a1 < NEG_HALF_PI) begin
      a2   = a1 + PI_Q30;
      flip = 1'b1;
    end
    rot_nxt.x    = GAIN_Q30;
    rot_nxt.y    = '0;
    rot_nxt.z    = a2;
    rot_nxt.flip = flip;
  end

  // side data: centered offset, sizes, saturated angle sum
  always_comb begin
    asum        = 21'(in_bus.rect_angle) + 21'(in_bus.ref_angle);
    side_nxt.ox = 19'(in_bus.rect_x) - HALF_Q;
    side_nxt.oy = 19'(in_bus.rect_y) - HALF_Q;
    side_nxt.fx = in_bus.ref_x;
    side_nxt.fy = in_bus.ref_y;
    side_nxt.rw = in_bus.rect_w;
    side_nxt.rh = in_bus.rect_h;
    side_nxt.fw = in_bus.ref_w;
    side_nxt.fh = in_bus.ref_h;
    if (asum > ANG_MAX) begin
      side_nxt.ang = ANG_MAX[19:0];
    end else if (asum < ANG_MIN) begin
      side_nxt.ang = ANG_MIN[19:0];
    end else begin
      side_nxt.ang = asum[19:0];
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_bus.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      side_r <= side_nxt;
    end
  end

  assign valid_o = valid_r;
  assign rot_o   = rot_r;
  assign side_o  = side_r;
endmodule

// ----- hw/rtl/rfp_scale.sv -----
// rfp_scale: rotate, scale and translate stages plus the output register;
// produces the pipeline advance. Depends on rfp_pkg and rfp_out_if.
module rfp_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  rfp_pkg::rot_t  rot_i,
  input  rfp_pkg::side_t side_i,
  output logic           en,
  rfp_out_if.source      out_bus
);
  import rfp_pkg::*;

  localparam logic signed [51:0] RND_CORE = 52'sd1 <<< (CORE_FRAC - 1);
  localparam logic [33:0]        RND_WH   = 34'd1 << (FRAC_BITS - 1);
  localparam logic signed [37:0] RND_XY   = 38'sd1 <<< (FRAC_BITS - 1);

  // stage 1: products
  logic               v1_r;
  logic signed [50:0] cx_r, sy_r, sx_r, cy_r;
  logic [33:0]        pw_r, ph_r;
  side_t              s1_r;
  logic signed [18:0] ox_e, oy_e;

  // stage 2: rounded rotation, saturated sizes
  logic               v2_r;
  logic signed [19:0] nx_r, ny_r;
  logic [16:0]        nw_r, nh_r;
  side_t              s2_r;
  logic signed [51:0] sum_x, sum_y;
  logic [33:0]        sum_w, sum_h;
  logic [18:0]        nw_c, nh_c;

  // stage 3: scaled offsets
  logic               v3_r;
  logic signed [37:0] px_r, py_r;
  logic [16:0]        nw3_r, nh3_r;
  side_t              s3_r;
  logic signed [17:0] fw_s, fh_s;

  // output register
  logic               out_valid_r;
  logic signed [17:0] ox_r, oy_r;
  logic [16:0]        ow_r, oh_r;
  logic signed [19:0] oa_r;
  logic signed [37:0] rx, ry;
  logic signed [22:0] tx, ty;
  logic signed [17:0] sat_x, sat_y;

  // whole chain advances when the output register is free or drained
  assign en = !out_valid_r || out_bus.ready;

  // a half-turn flip negates cosine and sine, applied to the offset instead
  always_comb begin
    ox_e = rot_i.flip ? -side_i.ox : side_i.ox;
    oy_e = rot_i.flip ? -side_i.oy : side_i.oy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= rot_i.x * ox_e;
      sy_r <= rot_i.y * oy_e;
      sx_r <= rot_i.y * ox_e;
      cy_r <= rot_i.x * oy_e;
      pw_r <= 34'(side_i.rw) * 34'(side_i.fw);
      ph_r <= 34'(side_i.rh) * 34'(side_i.fh);
      s1_r <= side_i;
    end
  end

  // round rotation back to Q.F, round and clamp sizes
  always_comb begin
    sum_x = 52'(cx_r) - 52'(sy_r) + RND_CORE;
    sum_y = 52'(sx_r) + 52'(cy_r) + RND_CORE;
    sum_w = pw_r + RND_WH;
    sum_h = ph_r + RND_WH;
    nw_c  = 19'(sum_w[FRAC_BITS +: 18]);
    nh_c  = 19'(sum_h[FRAC_BITS +: 18]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= sum_x[CORE_FRAC +: 20];
      ny_r <= sum_y[CORE_FRAC +: 20];
      nw_r <= (nw_c > 19'(WH_MAX)) ? WH_MAX : nw_c[16:0];
      nh_r <= (nh_c > 19'(WH_MAX)) ? WH_MAX : nh_c[16:0];
      s2_r <= s1_r;
    end
  end

  // scale by reference size
  assign fw_s = {1'b0, s2_r.fw};
  assign fh_s = {1'b0, s2_r.fh};

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= nx_r * fw_s;
      py_r  <= ny_r * fh_s;
      nw3_r <= nw_r;
      nh3_r <= nh_r;
      s3_r  <= s2_r;
    end
  end

  // round, translate by reference center, clamp
  always_comb begin
    rx = px_r + RND_XY;
    ry = py_r + RND_XY;
    tx = 23'($signed(rx[FRAC_BITS +: 22])) + 23'(s3_r.fx);
    ty = 23'($signed(ry[FRAC_BITS +: 22])) + 23'(s3_r.fy);
    if (tx > XY_MAX) begin
      sat_x = XY_MAX[17:0];
    end else if (tx < XY_MIN) begin
      sat_x = XY_MIN[17:0];
    end else begin
      sat_x = tx[17:0];
    end
    if (ty > XY_MAX) begin
      sat_y = XY_MAX[17:0];
    end else if (ty < XY_MIN) begin
      sat_y = XY_MIN[17:0];
    end else begin
      sat_y = ty[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= sat_x;
      oy_r <= sat_y;
      ow_r <= nw3_r;
      oh_r <= nh3_r;
      oa_r <= s3_r.ang;
    end
  end

  // valid bits of the arithmetic stages and the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= valid_i;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_x     = ox_r;
  assign out_bus.out_y     = oy_r;
  assign out_bus.out_w     = ow_r;
  assign out_bus.out_h     = oh_r;
  assign out_bus.out_angle = oa_r;
endmodule
